// File: rtl/edf_pkg.sv
// Shared types, codes and constants of the deadline scheduler.
`default_nettype none
package edf_pkg;

  localparam int NUM_TASKS_DEF   = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int TASK_SLOTS      = 4;
  localparam int MAX_EVENTS      = 23;
  localparam int EV_CNT_W        = 5;
  localparam int CFG_IDX_W       = 4;

  typedef enum logic [2:0] {
    EV_START   = 3'd0,
    EV_END     = 3'd1,
    EV_PREEMPT = 3'd2,
    EV_MISS    = 3'd3,
    EV_DROP    = 3'd4,
    EV_SUM     = 3'd5
  } ev_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERIOD_0 = 4'd0,
    REG_PERIOD_1 = 4'd1,
    REG_PERIOD_2 = 4'd2,
    REG_PERIOD_3 = 4'd3,
    REG_CPU_0    = 4'd4,
    REG_CPU_1    = 4'd5,
    REG_CPU_2    = 4'd6,
    REG_CPU_3    = 4'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_RUN, ST_MISS, ST_SCAN, ST_MEMIT, ST_REL, ST_REO1,
    ST_SORT, ST_REO2, ST_REO3, ST_START, ST_SUM
  } state_t;

  typedef enum logic [2:0] {
    OP_HOLD, OP_SHIFT, OP_SORT, OP_MISS, OP_WRITE
  } cell_op_t;

  typedef struct packed {
    logic        valid;
    logic        miss;
    logic        prem;
    logic [1:0]  task_id;
    logic [15:0] left;
    logic [31:0] order;
    logic [31:0] deadline;
  } job_t;

  typedef struct packed {
    cell_op_t op;
    logic     wr_sel;
    logic     lower;
    logic     upper;
  } cell_ctrl_t;

  function automatic logic goes_before(input job_t a, input job_t b);
    goes_before = a.valid && (!b.valid || (a.deadline < b.deadline) ||
                  ((a.deadline == b.deadline) && (a.order < b.order)));
  endfunction

endpackage
`default_nettype wire

// File: rtl/edf_cell.sv
// One queue slot: holds a job, swaps or shifts with its neighbors.
`default_nettype none
module edf_cell (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire edf_pkg::cell_ctrl_t      ctrl,
  input  wire edf_pkg::job_t            wr_data,
  input  wire edf_pkg::job_t            left_job,
  input  wire edf_pkg::job_t            right_job,
  input  wire logic [31:0]              cur_time,
  input  wire logic [3:0][15:0]         periods,
  output edf_pkg::job_t                 job
);
  import edf_pkg::*;

  job_t job_r, job_nxt;

  always_comb begin
    job_nxt = job_r;
    unique case (ctrl.op)
      OP_HOLD:  job_nxt = job_r;
      OP_SHIFT: job_nxt = right_job;
      OP_SORT: begin
        if (ctrl.lower && goes_before(right_job, job_r)) begin
          job_nxt = right_job;
        end else if (ctrl.upper && goes_before(job_r, left_job)) begin
          job_nxt = left_job;
        end
      end
      OP_MISS: begin
        // push a late job out one period and flag it for reporting
        if (job_r.valid && (job_r.deadline <= cur_time)) begin
          job_nxt.deadline = job_r.deadline + 32'(periods[job_r.task_id]);
          job_nxt.miss     = 1'b1;
        end
      end
      OP_WRITE: begin
        if (ctrl.wr_sel) begin
          job_nxt = wr_data;
        end
      end
      default: job_nxt = job_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r <= '0;
    end else begin
      job_r <= job_nxt;
    end
  end

  assign job = job_r;

endmodule
`default_nettype wire

// File: rtl/edf_periodic_task_scheduler_unit.sv
// Top level of the earliest-deadline-first periodic task scheduler.
`default_nettype none
// Each accepted item is one scheduler tick; the block answers with a burst of
// event items closed by a summary item (out_last high). Jobs live in a row of
// QUEUE_DEPTH cells kept in deadline order; a tick runs the head job, marks
// missed jobs in all cells at once, reports them by repeated scans of the row,
// appends releases, and reorders the row with an odd-even transposition sort
// of QUEUE_DEPTH passes. The length of a tick grows with the number of misses
// and with QUEUE_DEPTH, and a stalled output holds it. A final tick
// (in_final_tick) only runs the head job and then closes with the summary.
// Only one tick is in work at a time. Configuration writes are taken any time
// (cfg_ready is always high) but are meant to land between ticks. At most 23
// event items precede the summary in one tick; further events are dropped.
module edf_periodic_task_scheduler_unit #(
  parameter int NUM_TASKS   = edf_pkg::NUM_TASKS_DEF,
  parameter int QUEUE_DEPTH = edf_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_valid,
  output      logic                        cfg_ready,
  input  wire logic [edf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]                 cfg_data,
  input  wire logic                        in_valid,
  output      logic                        in_ready,
  input  wire logic                        in_final_tick,
  output      logic                        out_valid,
  input  wire logic                        out_ready,
  output      logic [2:0]                  out_event_kind,
  output      logic [1:0]                  out_task_id,
  output      logic [31:0]                 out_tick_time,
  output      logic [15:0]                 out_time_left,
  output      logic [31:0]                 out_waiting_sum,
  output      logic [31:0]                 out_jobs_created,
  output      logic                        out_last
);
  import edf_pkg::*;

  localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  // configuration registers
  logic [3:0][15:0] period_r, cpu_r;
  logic [3:0][15:0] period_eff;

  // tick state
  state_t        state_r, state_nxt;
  logic [31:0]   cur_time_r, cur_time_nxt;
  logic [31:0]   waiting_r, waiting_nxt;
  logic [31:0]   created_r, created_nxt;
  logic [31:0]   next_order_r, next_order_nxt;
  logic [31:0]   last_started_r, last_started_nxt;
  logic          begun_r, begun_nxt;
  logic          fin_r, fin_nxt;
  logic          first_r, first_nxt;
  logic [3:0][15:0] countdown_r, countdown_nxt;
  logic [CW-1:0] qcount_r, qcount_nxt;
  logic [EV_CNT_W-1:0] ev_cnt_r, ev_cnt_nxt;
  logic [1:0]    t_r, t_nxt;
  logic [QW-1:0] ptr_r, ptr_nxt;
  logic [QW-1:0] sort_cnt_r, sort_cnt_nxt;
  logic          best_ok_r, best_ok_nxt;
  logic [17:0]   best_key_r, best_key_nxt;
  logic [QW-1:0] best_idx_r, best_idx_nxt;
  logic [31:0]   old_order_r, old_order_nxt;
  logic [15:0]   old_left_r, old_left_nxt;
  logic [1:0]    old_task_r, old_task_nxt;

  // output register
  logic          out_valid_r;
  ev_kind_t      o_kind_r;
  logic [1:0]    o_task_r;
  logic [31:0]   o_time_r, o_ws_r, o_jc_r;
  logic [15:0]   o_left_r;
  logic          o_last_r;

  // event request from the sequencer
  logic          ev_req, ev_sum, capped, slot_free, adv, load_out;
  ev_kind_t      ev_kind;
  logic [1:0]    ev_task;
  logic [15:0]   ev_left;

  // row of cells
  job_t          q_arr [QUEUE_DEPTH];
  job_t          left_in [QUEUE_DEPTH];
  job_t          right_in [QUEUE_DEPTH];
  cell_ctrl_t    cctrl [QUEUE_DEPTH];
  cell_op_t      cell_op;
  logic [QW-1:0] wr_idx;
  job_t          wr_data;

  // frequently used views
  job_t          h, sc, wr_src;
  logic [15:0]   h_cpu, rel_cpu;
  logic          q_any, q_full, accept;
  logic          cond_a, start3, start_fin, rel_now, scan_hit, scan_last, t_last;
  logic          sort_done;

  assign h         = q_arr[0];
  assign sc        = q_arr[ptr_r];
  assign h_cpu     = cpu_r[h.task_id];
  assign rel_cpu   = cpu_r[t_r];
  assign q_any     = (qcount_r != '0);
  assign q_full    = (qcount_r == CW'(QUEUE_DEPTH));
  assign accept    = in_valid && in_ready;
  assign cond_a    = h.prem && (h.left != h_cpu) && (h.order != last_started_r);
  assign start3    = (h.left != h_cpu) && (h.order != last_started_r);
  assign start_fin = q_any && (h.order != last_started_r) && (h.left == h_cpu);
  assign rel_now   = first_r || (countdown_r[t_r] <= 16'd1);
  assign scan_hit  = sc.valid && sc.miss &&
                     (!best_ok_r || ({sc.task_id, sc.left} < best_key_r));
  assign scan_last = (ptr_r == QW'(QUEUE_DEPTH - 1));
  assign sort_done = (sort_cnt_r == QW'(QUEUE_DEPTH - 1));
  assign t_last    = (t_r == 2'(NUM_TASKS - 1));
  assign wr_src    = q_arr[best_idx_r];

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      period_eff[i] = (period_r[i] == 16'd0) ? 16'd1 : period_r[i];
    end
  end

  // configuration port: never stalls
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        period_r[i] <= 16'd1;
        cpu_r[i]    <= 16'd0;
      end
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PERIOD_0: period_r[0] <= cfg_data;
        REG_PERIOD_1: period_r[1] <= cfg_data;
        REG_PERIOD_2: period_r[2] <= cfg_data;
        REG_PERIOD_3: period_r[3] <= cfg_data;
        REG_CPU_0:    cpu_r[0]    <= cfg_data;
        REG_CPU_1:    cpu_r[1]    <= cfg_data;
        REG_CPU_2:    cpu_r[2]    <= cfg_data;
        REG_CPU_3:    cpu_r[3]    <= cfg_data;
        default: ;
      endcase
    end
  end

  // event slot: events past the cap are swallowed, the summary never is
  assign capped    = (ev_cnt_r >= EV_CNT_W'(MAX_EVENTS)) && !ev_sum;
  assign slot_free = !out_valid_r || out_ready;
  assign adv       = !ev_req || capped || slot_free;
  assign load_out  = ev_req && !capped && slot_free;
  assign in_ready  = (state_r == ST_IDLE);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_final_tick) state_nxt = q_any ? ST_RUN : ST_SUM;
          else if (!begun_r) state_nxt = ST_REL;
          else               state_nxt = q_any ? ST_RUN : ST_MISS;
        end
      end
      ST_RUN:   if (adv) state_nxt = fin_r ? ST_SUM : ST_MISS;
      ST_MISS:  state_nxt = ST_SCAN;
      ST_SCAN: begin
        if (scan_last) state_nxt = (best_ok_r || scan_hit) ? ST_MEMIT : ST_REL;
      end
      ST_MEMIT: if (adv) state_nxt = ST_SCAN;
      ST_REL:   if (adv && t_last) state_nxt = first_r ? ST_SORT : ST_REO1;
      ST_REO1: begin
        if (!q_any)   state_nxt = ST_START;
        else if (adv) state_nxt = ST_SORT;
      end
      ST_SORT:  if (sort_done) state_nxt = first_r ? ST_START : ST_REO2;
      ST_REO2: begin
        if (adv) begin
          if (h.order == old_order_r)               state_nxt = ST_START;
          else if (old_left_r != cpu_r[old_task_r]) state_nxt = ST_REO3;
          else                                      state_nxt = ST_START;
        end
      end
      ST_REO3:  if (adv) state_nxt = ST_START;
      ST_START: if (adv) state_nxt = ST_SUM;
      ST_SUM:   if (adv) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath control and register updates
  always_comb begin
    cur_time_nxt     = cur_time_r;
    waiting_nxt      = waiting_r;
    created_nxt      = created_r;
    next_order_nxt   = next_order_r;
    last_started_nxt = last_started_r;
    begun_nxt        = begun_r;
    fin_nxt          = fin_r;
    first_nxt        = first_r;
    countdown_nxt    = countdown_r;
    qcount_nxt       = qcount_r;
    ev_cnt_nxt       = ev_cnt_r;
    t_nxt            = t_r;
    ptr_nxt          = ptr_r;
    sort_cnt_nxt     = sort_cnt_r;
    best_ok_nxt      = best_ok_r;
    best_key_nxt     = best_key_r;
    best_idx_nxt     = best_idx_r;
    old_order_nxt    = old_order_r;
    old_left_nxt     = old_left_r;
    old_task_nxt     = old_task_r;
    ev_req           = 1'b0;
    ev_sum           = 1'b0;
    ev_kind          = EV_START;
    ev_task          = 2'd0;
    ev_left          = 16'd0;
    cell_op          = OP_HOLD;
    wr_idx           = '0;
    wr_data          = h;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          fin_nxt      = in_final_tick;
          first_nxt    = !in_final_tick && !begun_r;
          begun_nxt    = begun_r || !in_final_tick;
          ev_cnt_nxt   = '0;
          t_nxt        = 2'd0;
          ptr_nxt      = '0;
          sort_cnt_nxt = '0;
          best_ok_nxt  = 1'b0;
          if (q_any) waiting_nxt = waiting_r + 32'(qcount_r) - 32'd1;
        end
      end
      ST_RUN: begin
        // run the head one unit; drop it when it ends
        if (h.left == 16'd1) begin
          ev_req  = 1'b1;
          ev_kind = EV_END;
          ev_task = h.task_id;
          if (adv) begin
            cell_op    = OP_SHIFT;
            qcount_nxt = qcount_r - CW'(1);
          end
        end else begin
          cell_op      = OP_WRITE;
          wr_data.left = h.left - 16'd1;
        end
      end
      ST_MISS: begin
        cell_op     = OP_MISS;
        ptr_nxt     = '0;
        best_ok_nxt = 1'b0;
      end
      ST_SCAN: begin
        // find the smallest (task, left) among flagged jobs
        if (scan_hit) begin
          best_ok_nxt  = 1'b1;
          best_key_nxt = {sc.task_id, sc.left};
          best_idx_nxt = ptr_r;
        end
        ptr_nxt = scan_last ? '0 : ptr_r + QW'(1);
      end
      ST_MEMIT: begin
        ev_req  = 1'b1;
        ev_kind = EV_MISS;
        ev_task = best_key_r[17:16];
        ev_left = best_key_r[15:0];
        if (adv) begin
          cell_op      = OP_WRITE;
          wr_idx       = best_idx_r;
          wr_data      = wr_src;
          wr_data.miss = 1'b0;
          best_ok_nxt  = 1'b0;
        end
      end
      ST_REL: begin
        if (rel_now && (rel_cpu != 16'd0) && q_full) begin
          ev_req  = 1'b1;
          ev_kind = EV_DROP;
          ev_task = t_r;
          ev_left = rel_cpu;
        end
        if (adv) begin
          if (rel_now) begin
            countdown_nxt[t_r] = period_eff[t_r];
            if ((rel_cpu != 16'd0) && !q_full) begin
              cell_op          = OP_WRITE;
              wr_idx           = qcount_r[QW-1:0];
              wr_data.valid    = 1'b1;
              wr_data.miss     = 1'b0;
              wr_data.prem     = 1'b0;
              wr_data.task_id  = t_r;
              wr_data.left     = rel_cpu;
              wr_data.order    = next_order_r;
              wr_data.deadline = cur_time_r + 32'(period_eff[t_r]);
              qcount_nxt       = qcount_r + CW'(1);
              next_order_nxt   = next_order_r + 32'd1;
              created_nxt      = created_r + 32'd1;
            end
          end else begin
            countdown_nxt[t_r] = countdown_r[t_r] - 16'd1;
          end
          t_nxt = t_r + 2'd1;
        end
      end
      ST_REO1: begin
        if (q_any) begin
          if (cond_a) begin
            ev_req  = 1'b1;
            ev_kind = EV_START;
            ev_task = h.task_id;
            ev_left = h.left;
          end
          if (adv) begin
            if (cond_a) last_started_nxt = h.order;
            cell_op       = OP_WRITE;
            wr_data.prem  = 1'b1;
            old_order_nxt = h.order;
            old_left_nxt  = h.left;
            old_task_nxt  = h.task_id;
          end
        end
      end
      ST_SORT: begin
        cell_op      = OP_SORT;
        sort_cnt_nxt = sort_cnt_r + QW'(1);
      end
      ST_REO2: begin
        if (h.order == old_order_r) begin
          cell_op      = OP_WRITE;
          wr_data.prem = 1'b0;
        end else if (old_left_r != cpu_r[old_task_r]) begin
          ev_req  = 1'b1;
          ev_kind = EV_PREEMPT;
          ev_task = old_task_r;
          ev_left = old_left_r;
        end else if (start3 && h.prem) begin
          ev_req  = 1'b1;
          ev_kind = EV_START;
          ev_task = h.task_id;
          ev_left = h.left;
          if (adv) begin
            last_started_nxt = h.order;
            cell_op          = OP_WRITE;
            wr_data.prem     = 1'b0;
          end
        end
      end
      ST_REO3: begin
        if (start3) begin
          ev_req  = 1'b1;
          ev_kind = EV_START;
          ev_task = h.task_id;
          ev_left = h.left;
          if (adv) last_started_nxt = h.order;
        end
      end
      ST_START: begin
        if (start_fin) begin
          ev_req  = 1'b1;
          ev_kind = EV_START;
          ev_task = h.task_id;
          ev_left = h.left;
          if (adv) last_started_nxt = h.order;
        end
      end
      ST_SUM: begin
        ev_req  = 1'b1;
        ev_sum  = 1'b1;
        ev_kind = EV_SUM;
        if (adv && !fin_r) cur_time_nxt = cur_time_r + 32'd1;
      end
      default: ;
    endcase

    if (load_out && !ev_sum) ev_cnt_nxt = ev_cnt_r + EV_CNT_W'(1);
  end

  // row of job cells
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign left_in[i]  = (i == 0) ? job_t'('0) : q_arr[(i > 0) ? i - 1 : 0];
    assign right_in[i] = (i == QUEUE_DEPTH - 1) ? job_t'('0)
                         : q_arr[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
    assign cctrl[i].op     = cell_op;
    assign cctrl[i].wr_sel = (wr_idx == QW'(i));
    assign cctrl[i].lower  = (i < QUEUE_DEPTH - 1) && ((i % 2) == int'(sort_cnt_r[0]));
    assign cctrl[i].upper  = (i > 0) && (((i + 1) % 2) == int'(sort_cnt_r[0]));

    edf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctrl      (cctrl[i]),
      .wr_data   (wr_data),
      .left_job  (left_in[i]),
      .right_job (right_in[i]),
      .cur_time  (cur_time_r),
      .periods   (period_eff),
      .job       (q_arr[i])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      cur_time_r     <= '0;
      waiting_r      <= '0;
      created_r      <= '0;
      next_order_r   <= '0;
      last_started_r <= '1;
      begun_r        <= 1'b0;
      fin_r          <= 1'b0;
      first_r        <= 1'b0;
      countdown_r    <= '0;
      qcount_r       <= '0;
      ev_cnt_r       <= '0;
      t_r            <= '0;
      ptr_r          <= '0;
      sort_cnt_r     <= '0;
      best_ok_r      <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      state_r        <= state_nxt;
      cur_time_r     <= cur_time_nxt;
      waiting_r      <= waiting_nxt;
      created_r      <= created_nxt;
      next_order_r   <= next_order_nxt;
      last_started_r <= last_started_nxt;
      begun_r        <= begun_nxt;
      fin_r          <= fin_nxt;
      first_r        <= first_nxt;
      countdown_r    <= countdown_nxt;
      qcount_r       <= qcount_nxt;
      ev_cnt_r       <= ev_cnt_nxt;
      t_r            <= t_nxt;
      ptr_r          <= ptr_nxt;
      sort_cnt_r     <= sort_cnt_nxt;
      best_ok_r      <= best_ok_nxt;
      out_valid_r    <= load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    best_key_r  <= best_key_nxt;
    best_idx_r  <= best_idx_nxt;
    old_order_r <= old_order_nxt;
    old_left_r  <= old_left_nxt;
    old_task_r  <= old_task_nxt;
    if (load_out) begin
      o_kind_r <= ev_kind;
      o_task_r <= ev_task;
      o_time_r <= cur_time_r;
      o_left_r <= ev_left;
      o_ws_r   <= ev_sum ? waiting_r : 32'd0;
      o_jc_r   <= ev_sum ? created_r : 32'd0;
      o_last_r <= ev_sum;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_kind   = o_kind_r;
  assign out_task_id      = o_task_r;
  assign out_tick_time    = o_time_r;
  assign out_time_left    = o_left_r;
  assign out_waiting_sum  = o_ws_r;
  assign out_jobs_created = o_jc_r;
  assign out_last         = o_last_r;

  logic [QUEUE_DEPTH-1:0] valid_vec;
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) valid_vec[i] = q_arr[i].valid;
  end

  a_last_is_summary: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last) |-> (out_event_kind == EV_SUM))
    else $error("last item is not a summary");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qcount_r <= CW'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_packed_queue: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |-> ($countones(valid_vec) == int'(qcount_r)))
    else $error("valid cells disagree with queue count");

  a_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ev_cnt_r <= EV_CNT_W'(MAX_EVENTS))
    else $error("event count past cap");

endmodule
`default_nettype wire
